[rtl/sapq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sapq_pkg;

  localparam int DEPTH_DEFAULT = 128;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] pri;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/sapq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module sapq_cell (
  input  wire logic                clk,
  input  wire sapq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occupied,
  input  wire sapq_pkg::entry_t    new_entry,
  input  wire logic                take_left,
  input  wire sapq_pkg::entry_t    left_entry,
  input  wire sapq_pkg::entry_t    right_entry,
  output logic                     take_here,
  output sapq_pkg::entry_t         entry
);

  // The new item belongs at or before this cell when the cell is free or holds
  // a strictly lower priority.
  assign take_here = !occupied || (new_entry.pri > entry.pri);

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      entry <= right_entry;
    end else if (ctrl.enq) begin
      if (take_left) begin
        entry <= left_entry;
      end else if (take_here) begin
        entry <= new_entry;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sorted_array_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Priority queue built from a row of DEPTH cells kept sorted by descending
// signed priority; equal priorities leave in arrival order.
// An item is accepted on a rising edge with start high and busy low. busy is
// always low: every cell compares the new priority with its own and shifts in
// the same cycle, so one item is accepted in every cycle.
// func selects enqueue (value, priority_req) or dequeue of the head entry.
// Each item gives exactly one result, registered on the edge that accepts it and
// shown for one cycle with done high: out_value and out_priority (zero unless dequeued),
// status, and count after the operation. The receiver cannot stall, and
// results are never held back.
// An enqueue on a full queue is refused with status full; a dequeue on an
// empty queue reports empty. Neither changes the contents.
// Reset clears the count and done; no clearing pass is needed, since cell
// occupancy follows from the count.
module sorted_array_priority_queue #(
  parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] priority_req,
  output logic                    done,
  output logic signed [31:0]      out_value,
  output logic signed [31:0]      out_priority,
  output logic [1:0]              status,
  output logic [7:0]              count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      entry_count_next;
  logic               full;
  logic               empty;
  logic               accept;
  sapq_pkg::cell_ctrl_t ctrl;
  sapq_pkg::entry_t   new_entry;
  sapq_pkg::entry_t   cells [DEPTH];
  logic               take [DEPTH];
  logic [1:0]         status_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (entry_count == CW'(DEPTH));
  assign empty     = (entry_count == '0);
  assign new_entry = '{value: value, pri: priority_req};
  assign ctrl.enq  = accept && (func == sapq_pkg::FUNC_ENQ) && !full;
  assign ctrl.deq  = accept && (func == sapq_pkg::FUNC_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             occupied;
    logic             take_left;
    sapq_pkg::entry_t left_entry;
    sapq_pkg::entry_t right_entry;

    assign occupied = (entry_count > CW'(i));
    if (i == 0) begin : g_first
      assign take_left  = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_mid
      assign take_left  = take[i-1];
      assign left_entry = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cells[i];
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end

    sapq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .new_entry  (new_entry),
      .take_left  (take_left),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .take_here  (take[i]),
      .entry      (cells[i])
    );
  end

  always_comb begin
    entry_count_next = entry_count;
    if (ctrl.enq) begin
      entry_count_next = entry_count + CW'(1);
    end else if (ctrl.deq) begin
      entry_count_next = entry_count - CW'(1);
    end
    case (func)
      sapq_pkg::FUNC_ENQ: status_next = full ? sapq_pkg::ST_FULL : sapq_pkg::ST_ENQUEUED;
      sapq_pkg::FUNC_DEQ: status_next = empty ? sapq_pkg::ST_EMPTY : sapq_pkg::ST_DEQUEUED;
      default:            status_next = sapq_pkg::ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      count  <= 8'(entry_count_next);
      if (ctrl.deq) begin
        out_value    <= cells[0].value;
        out_priority <= cells[0].pri;
      end else begin
        out_value    <= '0;
        out_priority <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import sapq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 500;

  typedef struct {
    logic signed [31:0] val;
    logic signed [31:0] pri;
    logic [1:0]         st;
    logic [7:0]         cnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = FUNC_ENQ;
  logic signed [31:0] value = '0;
  logic signed [31:0] priority_req = '0;
  logic busy;
  logic done;
  logic signed [31:0] out_value;
  logic signed [31:0] out_priority;
  logic [1:0] status;
  logic [7:0] count;

  entry_t   shadow_rows[DEPTH];
  int       shadow_held = 0;
  outcome_t pending_outcomes[$];
  int       fail_count = 0;
  int       items_sent = 0;
  int       quiet_cycles = 0;
  int       max_held = 0;
  int       idle_pct = 0;
  int       status_tally[4] = '{0, 0, 0, 0};

  sorted_array_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .priority_req(priority_req),
    .done(done),
    .out_value(out_value),
    .out_priority(out_priority),
    .status(status),
    .count(count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic outcome_t apply_queue_op(input logic f, input logic signed [31:0] v,
                                              input logic signed [31:0] p);
    outcome_t o;
    int pos;
    o.val = '0;
    o.pri = '0;
    if (f == FUNC_ENQ) begin
      if (shadow_held >= DEPTH) begin
        o.st = ST_FULL;
      end else begin
        pos = shadow_held;
        while (pos > 0 && $signed(p) > $signed(shadow_rows[pos - 1].pri)) begin
          shadow_rows[pos] = shadow_rows[pos - 1];
          pos--;
        end
        shadow_rows[pos].value = v;
        shadow_rows[pos].pri = p;
        shadow_held++;
        o.st = ST_ENQUEUED;
      end
    end else begin
      if (shadow_held == 0) begin
        o.st = ST_EMPTY;
      end else begin
        o.val = shadow_rows[0].value;
        o.pri = shadow_rows[0].pri;
        for (int i = 0; i + 1 < shadow_held; i++) shadow_rows[i] = shadow_rows[i + 1];
        shadow_held--;
        o.st = ST_DEQUEUED;
      end
    end
    o.cnt = shadow_held[7:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (done) begin
        status_tally[status]++;
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result: status %0d count %0d", status, count);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_value !== want.val) begin
            $error("out_value: expected %0d, got %0d", want.val, out_value);
            fail_count++;
          end
          if (out_priority !== want.pri) begin
            $error("out_priority: expected %0d, got %0d", want.pri, out_priority);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, got %0d", want.cnt, count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_outcomes.push_back(apply_queue_op(func, value, priority_req));
        if (shadow_held > max_held) max_held = shadow_held;
      end
      if ((start && !busy) || done) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input logic f, input logic signed [31:0] v,
                           input logic signed [31:0] p);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    value <= v;
    priority_req <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] p;
    case ($urandom_range(0, 3))
      0: p = $signed($urandom_range(0, 7)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: p = 32'sh7fffffff;
          1: p = 32'sh80000000;
          2: p = 32'sd0;
          default: p = -32'sd1;
        endcase
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic test_directed();
    send_item(FUNC_DEQ, 32'sd0, 32'sd0);
    send_item(FUNC_ENQ, 32'sh7fffffff, 32'sh80000000);
    send_item(FUNC_ENQ, 32'sh80000000, 32'sh7fffffff);
    send_item(FUNC_ENQ, 32'sd0, 32'sd0);
    send_item(FUNC_ENQ, -32'sd1, -32'sd1);
    send_item(FUNC_ENQ, 32'sd1, 32'sd0);
    send_item(FUNC_ENQ, 32'sd2, 32'sd0);
    send_item(FUNC_ENQ, 32'shaaaa5555, 32'sd1);
    send_item(FUNC_ENQ, 32'sh5555aaaa, -32'sd2);
    repeat (9) send_item(FUNC_DEQ, $urandom, $urandom);
    drain_results();
  endtask

  task automatic test_full_queue();
    repeat (DEPTH) send_item(FUNC_ENQ, $urandom, pick_priority());
    repeat (2) send_item(FUNC_ENQ, $urandom, pick_priority());
    send_item(FUNC_DEQ, $urandom, $urandom);
    send_item(FUNC_ENQ, $urandom, pick_priority());
    send_item(FUNC_ENQ, $urandom, pick_priority());
    repeat (DEPTH + 1) send_item(FUNC_DEQ, $urandom, $urandom);
    drain_results();
  endtask

  task automatic test_random_mix(input int n);
    int enq_pct;
    logic f;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 20;
        endcase
      end
      f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      send_item(f, $urandom, pick_priority());
    end
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 23;
    test_directed();
    test_full_queue();
    test_random_mix(336);
    idle_pct = 61;
    test_random_mix(336);
    idle_pct = 0;
    test_random_mix(336);
    test_full_queue();
    repeat (5) @(posedge clk);
    $display("Covered %0d items: %0d enqueued, %0d dequeued, %0d refused as full, %0d empty.",
             items_sent, status_tally[ST_ENQUEUED], status_tally[ST_DEQUEUED],
             status_tally[ST_FULL], status_tally[ST_EMPTY]);
    $display("Occupancy reached %0d of %0d entries.", max_held, DEPTH);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
